// ===== rtl/core/tcp_pkg.sv =====
// Shared types, constants and the arctangent table of the tilt control pipeline.
// Used by tcp_cordic_unit, tilt_control_pipeline_top and the testbench; depends on nothing.
`default_nettype none
package tcp_pkg;

    localparam int LANE_W = 44;
    localparam int ZW = 28;
    localparam int RAW_W = 24;
    localparam int SAMPLE_W = 16;
    localparam logic signed [ZW-1:0] HALF_TURN = 28'sd16777216;
    localparam logic [15:0] INV_GAIN = 16'd39797;
    localparam logic signed [17:0] Q_ONE = 18'sd16384;

    localparam logic [1:0] KIND_SAMPLE = 2'd0;
    localparam logic [1:0] KIND_MISSING = 2'd1;
    localparam logic [1:0] KIND_CALIBRATE = 2'd2;
    localparam logic [1:0] KIND_CLEAR = 2'd3;

    localparam logic [1:0] REG_SWAP_AXES = 2'd0;
    localparam logic [1:0] REG_INVERT_PITCH = 2'd1;
    localparam logic [1:0] REG_INVERT_ROLL = 2'd2;

    typedef struct packed {
        logic done;
        logic busy;
    } cordic_status_t;

    function automatic logic signed [ZW-1:0] atan_unit(input logic [4:0] idx);
        logic signed [ZW-1:0] v;
        case (idx)
            5'd0: v = 28'sd4194304;
            5'd1: v = 28'sd2476042;
            5'd2: v = 28'sd1308273;
            5'd3: v = 28'sd664100;
            5'd4: v = 28'sd333339;
            5'd5: v = 28'sd166832;
            5'd6: v = 28'sd83436;
            5'd7: v = 28'sd41721;
            5'd8: v = 28'sd20861;
            5'd9: v = 28'sd10430;
            5'd10: v = 28'sd5215;
            5'd11: v = 28'sd2608;
            5'd12: v = 28'sd1304;
            5'd13: v = 28'sd652;
            5'd14: v = 28'sd326;
            5'd15: v = 28'sd163;
            5'd16: v = 28'sd81;
            5'd17: v = 28'sd41;
            5'd18: v = 28'sd20;
            5'd19: v = 28'sd10;
            5'd20: v = 28'sd5;
            5'd21: v = 28'sd3;
            5'd22: v = 28'sd1;
            5'd23: v = 28'sd1;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/core/tilt_control_pipeline_top.sv =====
// Top level of the tilt control pipeline: sequencer, gain correction and output stage.
// Depends on tcp_pkg and tcp_cordic_unit.
`default_nettype none
// A sample word (kind 0) is accepted and passes through the states LOAD1, RUN1, GAIN, LOAD2,
// RUN2, POST and OUT. Two CORDIC vectoring passes share one rotation unit at one step per
// cycle. Each pass has a load state and waits in its run state until the unit reports
// completion. Gain correction, final scaling and the output register each have their own
// state. Sensor missing, calibrate and clear words go straight to the output state. A new
// word is accepted only when the sequencer is idle. A finished result waits in the output
// register until it is taken.
module tilt_control_pipeline_top #(
    parameter int CORDIC_STEPS = 16,
    parameter int SAMPLE_BITS = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [1:0]  kind,
    input  wire logic signed [15:0] accel_x,
    input  wire logic signed [15:0] accel_y,
    input  wire logic signed [15:0] accel_z,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic signed [15:0] pitch_out,
    output logic signed [15:0] roll_out,
    output logic             sample_valid,
    output logic             is_calibrated,
    output logic             command_ok,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic        cfg_data
);
    localparam int LW = tcp_pkg::LANE_W;
    localparam int ZW = tcp_pkg::ZW;
    localparam logic [tcp_pkg::RAW_W-1:0] SMASK =
        (tcp_pkg::RAW_W'(1) << SAMPLE_BITS) - 1'b1;
    localparam logic signed [tcp_pkg::RAW_W:0] SSPAN =
        (tcp_pkg::RAW_W+1)'(1) << SAMPLE_BITS;

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_LOAD1 = 8'b0000_0010,
        S_RUN1 = 8'b0000_0100,
        S_GAIN = 8'b0000_1000,
        S_LOAD2 = 8'b0001_0000,
        S_RUN2 = 8'b0010_0000,
        S_POST = 8'b0100_0000,
        S_OUT = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;
    logic swap_reg, inv_p_reg, inv_r_reg;
    logic signed [15:0] p_off_reg, r_off_reg, last_p_reg, last_r_reg;
    logic active_reg, last_valid_reg, ok_reg;
    logic signed [LW-1:0] ax_reg, ay_reg, az_reg;
    logic signed [ZW-1:0] zp_reg;
    logic signed [LW+16:0] prod_reg;
    logic out_valid_reg;
    logic signed [15:0] pitch_reg, roll_reg;
    logic sv_reg, cal_reg, cok_reg;

    logic signed [LW-1:0] lx, ly, lz, c_y, c_x;
    logic c_nz;
    tcp_pkg::cordic_status_t c_st;
    logic signed [ZW-1:0] c_angle;
    logic signed [LW-1:0] c_mag;
    logic accept;
    logic out_free;

    function automatic logic signed [LW-1:0] to_lane(input logic [15:0] raw);
        logic [tcp_pkg::RAW_W-1:0] m;
        logic signed [tcp_pkg::RAW_W:0] v;
        m = {{(tcp_pkg::RAW_W-16){1'b0}}, raw} & SMASK;
        v = $signed({1'b0, m});
        if (m[SAMPLE_BITS-1])
            v = v - SSPAN;
        return LW'(v) <<< 16;
    endfunction

    function automatic logic signed [17:0] to_q(input logic signed [ZW-1:0] z);
        logic signed [ZW:0] s;
        logic signed [ZW-8:0] q;
        s = (ZW+1)'(z) + (ZW+1)'(128);
        q = (ZW-7)'(s >>> 8);
        if (q > (ZW-7)'(tcp_pkg::Q_ONE))
            return tcp_pkg::Q_ONE;
        if (q < -(ZW-7)'(tcp_pkg::Q_ONE))
            return -tcp_pkg::Q_ONE;
        return 18'(q);
    endfunction

    function automatic logic signed [15:0] clamp_q(input logic signed [17:0] v);
        if (v > tcp_pkg::Q_ONE)
            return 16'(tcp_pkg::Q_ONE);
        if (v < -tcp_pkg::Q_ONE)
            return 16'(-tcp_pkg::Q_ONE);
        return 16'(v);
    endfunction

    function automatic logic signed [15:0] sat16(input logic signed [16:0] v);
        if (v > 17'sd32767)
            return 16'sd32767;
        if (v < -17'sd32768)
            return -16'sd32768;
        return 16'(v);
    endfunction

    assign lx = to_lane(accel_x);
    assign ly = to_lane(accel_y);
    assign lz = to_lane(accel_z);
    assign in_ready = (state_reg == S_IDLE);
    assign accept = in_valid && in_ready;
    assign cfg_ready = 1'b1;
    assign out_free = !out_valid_reg || out_ready;

    assign c_y = (state_reg == S_LOAD1) ? -ax_reg : ay_reg;
    assign c_x = (state_reg == S_LOAD1) ? az_reg : LW'(prod_reg >>> 16);
    assign c_nz = (state_reg == S_LOAD1);

    tcp_cordic_unit #(
        .CORDIC_STEPS(CORDIC_STEPS)
    ) u_cordic (
        .clk(clk),
        .rst_n(rst_n),
        .start((state_reg == S_LOAD1) || (state_reg == S_LOAD2)),
        .neg_zero(c_nz),
        .y_in(c_y),
        .x_in(c_x),
        .status(c_st),
        .angle(c_angle),
        .mag(c_mag)
    );

    logic signed [17:0] pq, rq, pa, ra;

    always_comb
    begin
        pq = to_q(zp_reg);
        rq = to_q(-c_angle);
        pa = swap_reg ? rq : pq;
        ra = swap_reg ? pq : rq;
        if (inv_p_reg)
            pa = -pa;
        if (inv_r_reg)
            ra = -ra;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
                if (accept)
                    state_next = (kind == tcp_pkg::KIND_SAMPLE) ? S_LOAD1 : S_OUT;
            S_LOAD1: state_next = S_RUN1;
            S_RUN1:
                if (c_st.done)
                    state_next = S_GAIN;
            S_GAIN: state_next = S_LOAD2;
            S_LOAD2: state_next = S_RUN2;
            S_RUN2:
                if (c_st.done)
                    state_next = S_POST;
            S_POST: state_next = S_OUT;
            S_OUT:
                if (out_free)
                    state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            swap_reg <= 1'b0;
            inv_p_reg <= 1'b0;
            inv_r_reg <= 1'b0;
            p_off_reg <= '0;
            r_off_reg <= '0;
            active_reg <= 1'b0;
            last_p_reg <= '0;
            last_r_reg <= '0;
            last_valid_reg <= 1'b0;
            ok_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid)
            begin
                case (cfg_index)
                    tcp_pkg::REG_SWAP_AXES: swap_reg <= cfg_data;
                    tcp_pkg::REG_INVERT_PITCH: inv_p_reg <= cfg_data;
                    tcp_pkg::REG_INVERT_ROLL: inv_r_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (accept)
            begin
                case (kind)
                    tcp_pkg::KIND_SAMPLE: ok_reg <= 1'b1;
                    tcp_pkg::KIND_MISSING:
                    begin
                        last_p_reg <= '0;
                        last_r_reg <= '0;
                        last_valid_reg <= 1'b0;
                        ok_reg <= 1'b0;
                    end
                    tcp_pkg::KIND_CALIBRATE:
                    begin
                        ok_reg <= last_valid_reg;
                        if (last_valid_reg)
                        begin
                            p_off_reg <= sat16(17'(last_p_reg) + 17'(p_off_reg));
                            r_off_reg <= sat16(17'(last_r_reg) + 17'(r_off_reg));
                            active_reg <= 1'b1;
                        end
                    end
                    default:
                    begin
                        p_off_reg <= '0;
                        r_off_reg <= '0;
                        active_reg <= 1'b0;
                        ok_reg <= 1'b1;
                    end
                endcase
            end
            if (state_reg == S_POST)
            begin
                last_p_reg <= clamp_q(pa - 18'(p_off_reg));
                last_r_reg <= clamp_q(ra - 18'(r_off_reg));
                last_valid_reg <= 1'b1;
            end
            out_valid_reg <= ((state_reg == S_OUT) && out_free) ||
                             (out_valid_reg && !out_ready);
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ax_reg <= lx;
            ay_reg <= ly;
            az_reg <= lz;
        end
        if ((state_reg == S_RUN1) && c_st.done)
            zp_reg <= c_angle;
        if (state_reg == S_GAIN)
            prod_reg <= (LW+17)'(c_mag) * $signed({1'b0, tcp_pkg::INV_GAIN});
        if ((state_reg == S_OUT) && out_free)
        begin
            pitch_reg <= last_p_reg;
            roll_reg <= last_r_reg;
            sv_reg <= last_valid_reg;
            cal_reg <= active_reg;
            cok_reg <= ok_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign pitch_out = pitch_reg;
    assign roll_out = roll_reg;
    assign sample_valid = sv_reg;
    assign is_calibrated = cal_reg;
    assign command_ok = cok_reg;

    a_done_in_run: assert property (@(posedge clk) disable iff (!rst_n)
        c_st.done |-> (state_reg == S_RUN1) || (state_reg == S_RUN2))
        else $error("CORDIC finished outside a run state.");
    a_inactive_zero: assert property (@(posedge clk) disable iff (!rst_n)
        !active_reg |-> (p_off_reg == '0) && (r_off_reg == '0))
        else $error("Offsets are non-zero while calibration is inactive.");
    a_neutral: assert property (@(posedge clk) disable iff (!rst_n)
        !last_valid_reg |-> (last_p_reg == '0) && (last_r_reg == '0))
        else $error("Neutral sample holds a non-zero value.");
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        (last_p_reg <= 16'sd16384) && (last_p_reg >= -16'sd16384))
        else $error("Stored pitch is out of range.");
endmodule
`default_nettype wire

// ===== rtl/core/tcp_cordic_unit.sv =====
// Vectoring CORDIC unit that performs one micro-rotation per clock cycle.
// Depends on tcp_pkg for lane widths and the arctangent table.
`default_nettype none
module tcp_cordic_unit #(
    parameter int CORDIC_STEPS = 16
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 start,
    input  wire logic                                 neg_zero,
    input  wire logic signed [tcp_pkg::LANE_W-1:0]    y_in,
    input  wire logic signed [tcp_pkg::LANE_W-1:0]    x_in,
    output tcp_pkg::cordic_status_t                   status,
    output logic signed [tcp_pkg::ZW-1:0]             angle,
    output logic signed [tcp_pkg::LANE_W-1:0]         mag
);
    localparam int CNT_W = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
    localparam logic [CNT_W-1:0] LAST = CNT_W'(CORDIC_STEPS - 1);

    logic signed [tcp_pkg::LANE_W-1:0] x_reg, x_next, y_reg, y_next;
    logic signed [tcp_pkg::ZW-1:0] z_reg, z_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic busy_reg, busy_next, done_reg, done_next, zero_reg, zero_next;
    logic signed [tcp_pkg::LANE_W-1:0] dx, dy;
    logic signed [tcp_pkg::ZW-1:0] at;

    assign dx = y_reg >>> cnt_reg;
    assign dy = x_reg >>> cnt_reg;
    assign at = tcp_pkg::atan_unit(5'(cnt_reg));

    always_comb
    begin
        x_next = x_reg;
        y_next = y_reg;
        z_next = z_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        zero_next = zero_reg;
        done_next = 1'b0;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next = '0;
            zero_next = (x_in == '0) && (y_in == '0);
            if (x_in < 0)
            begin
                z_next = ((y_in < 0) || ((y_in == '0) && neg_zero)) ?
                         -tcp_pkg::HALF_TURN : tcp_pkg::HALF_TURN;
                x_next = -x_in;
                y_next = -y_in;
            end
            else
            begin
                z_next = '0;
                x_next = x_in;
                y_next = y_in;
            end
        end
        else if (busy_reg)
        begin
            if (y_reg < 0)
            begin
                x_next = x_reg - dx;
                y_next = y_reg + dy;
                z_next = z_reg - at;
            end
            else
            begin
                x_next = x_reg + dx;
                y_next = y_reg - dy;
                z_next = z_reg + at;
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == LAST)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
        y_reg <= y_next;
        z_reg <= z_next;
        zero_reg <= zero_next;
    end

    assign status.done = done_reg;
    assign status.busy = busy_reg;
    assign angle = zero_reg ? '0 : z_reg;
    assign mag = zero_reg ? '0 : x_reg;
endmodule
`default_nettype wire

// ===== tb/testbench.sv =====
// Self-checking testbench of tilt_control_pipeline_top: drives sample, missing, calibrate and
// clear words, predicts each result word with a bit-accurate CORDIC model and checks it.
// Depends on tcp_pkg and the RTL of the tilt control pipeline.
`default_nettype none

class tilt_scoreboard;
    typedef struct packed {
        logic signed [15:0] pitch;
        logic signed [15:0] roll;
        logic               valid;
        logic               calibrated;
        logic               ok;
    } tilt_word_t;

    tilt_word_t pending[$];
    int mismatches;
    bit swap_axes, invert_pitch, invert_roll;
    int pitch_offset, roll_offset, last_pitch, last_roll;
    bit offsets_active, last_valid;

    function new();
        mismatches = 0;
        swap_axes = 0;
        invert_pitch = 0;
        invert_roll = 0;
        pitch_offset = 0;
        roll_offset = 0;
        last_pitch = 0;
        last_roll = 0;
        offsets_active = 0;
        last_valid = 0;
    endfunction

    function void set_register(logic [1:0] idx, bit val);
        if (idx == tcp_pkg::REG_SWAP_AXES) swap_axes = val;
        else if (idx == tcp_pkg::REG_INVERT_PITCH) invert_pitch = val;
        else if (idx == tcp_pkg::REG_INVERT_ROLL) invert_roll = val;
    endfunction

    function longint atan_step(int i);
        longint table_v[24] = '{4194304, 2476042, 1308273, 664100, 333339, 166832, 83436,
            41721, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20, 10, 5, 3, 1, 1};
        return table_v[i];
    endfunction

    function longint vectoring_angle(longint yv, longint xv, bit neg_zero, output longint mag);
        longint z;
        longint dx, dy;
        z = 0;
        if (xv == 0 && yv == 0)
        begin
            mag = 0;
            return 0;
        end
        if (xv < 0)
        begin
            z = ((yv < 0) || (yv == 0 && neg_zero)) ? -64'sd16777216 : 64'sd16777216;
            xv = -xv;
            yv = -yv;
        end
        for (int i = 0; i < 16; i++)
        begin
            dx = yv >>> i;
            dy = xv >>> i;
            if (yv < 0)
            begin
                xv -= dx;
                yv += dy;
                z -= atan_step(i);
            end
            else
            begin
                xv += dx;
                yv -= dy;
                z += atan_step(i);
            end
        end
        mag = xv;
        return z;
    endfunction

    function int clamp_unit(longint v);
        if (v > 16384) return 16384;
        if (v < -16384) return -16384;
        return int'(v);
    endfunction

    function int sat_word(int v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return v;
    endfunction

    function void note_input(logic [1:0] kind, logic signed [15:0] ax, logic signed [15:0] ay,
                             logic signed [15:0] az);
        longint m, unused, zp, zr;
        int p, r, t;
        bit ok;
        tilt_word_t w;
        ok = 0;
        case (kind)
            tcp_pkg::KIND_SAMPLE:
            begin
                zp = vectoring_angle(-(longint'(ax) * 65536), longint'(az) * 65536, 1, m);
                m = (m * 39797) >>> 16;
                zr = vectoring_angle(longint'(ay) * 65536, m, 0, unused);
                p = clamp_unit((zp + 128) >>> 8);
                r = clamp_unit((-zr + 128) >>> 8);
                if (swap_axes)
                begin
                    t = p;
                    p = r;
                    r = t;
                end
                if (invert_pitch) p = -p;
                if (invert_roll) r = -r;
                last_pitch = clamp_unit(longint'(p) - pitch_offset);
                last_roll = clamp_unit(longint'(r) - roll_offset);
                last_valid = 1;
                ok = 1;
            end
            tcp_pkg::KIND_MISSING:
            begin
                last_pitch = 0;
                last_roll = 0;
                last_valid = 0;
            end
            tcp_pkg::KIND_CALIBRATE:
            begin
                if (last_valid)
                begin
                    pitch_offset = sat_word(last_pitch + pitch_offset);
                    roll_offset = sat_word(last_roll + roll_offset);
                    offsets_active = 1;
                    ok = 1;
                end
            end
            default:
            begin
                pitch_offset = 0;
                roll_offset = 0;
                offsets_active = 0;
                ok = 1;
            end
        endcase
        w.pitch = last_pitch[15:0];
        w.roll = last_roll[15:0];
        w.valid = last_valid;
        w.calibrated = offsets_active;
        w.ok = ok;
        pending.push_back(w);
    endfunction

    function void check_result(tilt_word_t got);
        tilt_word_t exp_w;
        if (pending.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result word %h", got);
            return;
        end
        exp_w = pending.pop_front();
        if (got !== exp_w)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("expected %0d %0d %b %b %b, actual %0d %0d %b %b %b",
                         exp_w.pitch, exp_w.roll, exp_w.valid, exp_w.calibrated, exp_w.ok,
                         got.pitch, got.roll, got.valid, got.calibrated, got.ok);
        end
    endfunction
endclass

module testbench;
    logic clk = 0;
    logic rst_n = 0;
    logic in_valid = 0;
    logic in_ready;
    logic [1:0] kind = '0;
    logic signed [15:0] accel_x = '0;
    logic signed [15:0] accel_y = '0;
    logic signed [15:0] accel_z = '0;
    logic out_valid;
    logic out_ready = 0;
    logic signed [15:0] pitch_out, roll_out;
    logic sample_valid, is_calibrated, command_ok;
    logic cfg_valid = 0;
    logic cfg_ready;
    logic [1:0] cfg_index = '0;
    logic cfg_data = 0;

    tilt_scoreboard tilt_sb = new();
    int send_idle_pct = 17;
    int recv_idle_pct = 75;
    bit hold_receiver = 0;
    int quiet_cycles = 0;

    always #10 clk = ~clk;

    tilt_control_pipeline_top i_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .kind(kind),
        .accel_x(accel_x), .accel_y(accel_y), .accel_z(accel_z),
        .out_valid(out_valid), .out_ready(out_ready),
        .pitch_out(pitch_out), .roll_out(roll_out), .sample_valid(sample_valid),
        .is_calibrated(is_calibrated), .command_ok(command_ok),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            tilt_sb.check_result({pitch_out, roll_out, sample_valid, is_calibrated, command_ok});
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > 20000)
        begin
            $display("tilt_control_pipeline_top regression: fail");
            $finish;
        end
    end

    always @(negedge clk)
        out_ready <= !hold_receiver && ($urandom_range(99) >= recv_idle_pct);

    task automatic send_word(logic [1:0] k, logic signed [15:0] x, logic signed [15:0] y,
                             logic signed [15:0] z);
        while ($urandom_range(99) < send_idle_pct)
            @(negedge clk);
        in_valid = 1;
        kind <= k;
        accel_x <= x;
        accel_y <= y;
        accel_z <= z;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        tilt_sb.note_input(k, x, y, z);
        @(negedge clk);
        in_valid = 0;
    endtask

    task automatic drain();
        while (tilt_sb.pending.size() != 0)
            @(negedge clk);
        repeat (40) @(negedge clk);
    endtask

    task automatic write_register(logic [1:0] idx, bit val);
        cfg_valid = 1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        tilt_sb.set_register(idx, val);
        @(negedge clk);
        cfg_valid = 0;
    endtask

    task automatic set_registers(bit s, bit p, bit r);
        drain();
        write_register(tcp_pkg::REG_SWAP_AXES, s);
        write_register(tcp_pkg::REG_INVERT_PITCH, p);
        write_register(tcp_pkg::REG_INVERT_ROLL, r);
        write_register(2'd3, 1'b1);
    endtask

    function automatic logic signed [15:0] pick_axis();
        case ($urandom_range(5))
            0: return 16'sh8000;
            1: return 16'sh7fff;
            2: return '0;
            3: return 16'($urandom_range(2000) - 1000);
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic random_phase(int count);
        int pick;
        logic [1:0] k;
        for (int n = 0; n < count; n++)
        begin
            pick = $urandom_range(99);
            k = pick < 70 ? tcp_pkg::KIND_SAMPLE : pick < 80 ? tcp_pkg::KIND_MISSING :
                pick < 92 ? tcp_pkg::KIND_CALIBRATE : tcp_pkg::KIND_CLEAR;
            send_word(k, pick_axis(), pick_axis(), pick_axis());
        end
    endtask

    initial
    begin
        repeat (10) @(negedge clk);
        rst_n <= 1;
        @(negedge clk);
        send_word(tcp_pkg::KIND_CALIBRATE, 0, 0, 0);
        send_word(tcp_pkg::KIND_SAMPLE, 0, 0, 0);
        send_word(tcp_pkg::KIND_SAMPLE, 0, 0, -16384);
        send_word(tcp_pkg::KIND_SAMPLE, 0, 0, 16384);
        send_word(tcp_pkg::KIND_SAMPLE, 16'sh7fff, 16'sh7fff, 16'sh7fff);
        send_word(tcp_pkg::KIND_SAMPLE, 16'sh8000, 16'sh8000, 16'sh8000);
        send_word(tcp_pkg::KIND_SAMPLE, 16'sh8000, 16'sh7fff, 0);
        send_word(tcp_pkg::KIND_SAMPLE, 0, 16'sh8000, 0);
        send_word(tcp_pkg::KIND_SAMPLE, 1000, -2000, 8000);
        send_word(tcp_pkg::KIND_CALIBRATE, 0, 0, 0);
        send_word(tcp_pkg::KIND_SAMPLE, -3000, 4000, 9000);
        send_word(tcp_pkg::KIND_CALIBRATE, 0, 0, 0);
        send_word(tcp_pkg::KIND_CALIBRATE, 0, 0, 0);
        send_word(tcp_pkg::KIND_MISSING, 0, 0, 0);
        send_word(tcp_pkg::KIND_CALIBRATE, 0, 0, 0);
        send_word(tcp_pkg::KIND_CLEAR, 16'sh7fff, 16'sh8000, 16'sh7fff);
        set_registers(1, 1, 1);
        send_word(tcp_pkg::KIND_SAMPLE, 5000, 3000, 12000);
        send_word(tcp_pkg::KIND_SAMPLE, 16'sh8000, 16'sh7fff, 0);
        random_phase(300);

        hold_receiver = 1;
        fork
            begin
                repeat (400) @(negedge clk);
                hold_receiver = 0;
            end
            random_phase(10);
        join
        drain();
        set_registers(0, 1, 0);
        random_phase(150);
        send_idle_pct = 75;
        recv_idle_pct = 17;
        set_registers(1, 0, 1);
        random_phase(300);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_registers(0, 0, 0);
        random_phase(450);
        drain();
        if (tilt_sb.mismatches == 0 && tilt_sb.pending.size() == 0)
            $display("tilt_control_pipeline_top regression: pass");
        else
            $display("tilt_control_pipeline_top regression: fail");
        $finish;
    end
endmodule
`default_nettype wire

// ===== files.f =====
rtl/core/tcp_pkg.sv
rtl/core/tcp_cordic_unit.sv
rtl/core/tilt_control_pipeline_top.sv
tb/testbench.sv
